>>> rtl/core/rag_deadlock_detector_macros.svh
// Assertion macros used by rag_peel_engine. Define NO_ASSERTIONS to compile them out.
`ifndef RAG_DEADLOCK_DETECTOR_MACROS_SVH
`define RAG_DEADLOCK_DETECTOR_MACROS_SVH

`ifndef NO_ASSERTIONS
`define RAG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RAG_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RAG_ASSERT(lbl, prop, msg)
`define RAG_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> rtl/core/rag_pkg.sv
package rag_pkg;

    localparam int ID_W  = 5;
    localparam int IDX_W = 16;
    localparam logic [IDX_W-1:0] IDX_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        ST_CLEAR  = 2'd0,
        ST_DEAD   = 2'd1,
        ST_HALTED = 2'd2
    } status_t;

    typedef struct packed {
        logic [ID_W-1:0] proc_id;
        logic [ID_W-1:0] res_id;
        logic            is_assign;
    } edge_t;

    typedef struct packed {
        status_t          status;
        logic [IDX_W-1:0] edge_num;
        logic [ID_W-1:0]  dead_proc;
        logic             last;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_SWEEP,
        S_REPORT,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic rd_req;
        logic rd_asg;
        logic wr_req;
        logic wr_asg;
    } mem_ctl_t;

endpackage

>>> rtl/core/rag_stream_if.sv
interface rag_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/rag_graph_mem.sv
module rag_graph_mem #(
    parameter int NUM_PROCS = 32,
    parameter int NUM_RES   = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rag_pkg::mem_ctl_t              ctl,
    input  logic [$clog2(NUM_PROCS)-1:0]   rd_p_addr,
    input  logic [$clog2(NUM_RES)-1:0]     rd_r_addr,
    input  logic [$clog2(NUM_PROCS)-1:0]   wr_p_addr,
    input  logic [$clog2(NUM_RES)-1:0]     wr_r_addr,
    input  logic [NUM_RES-1:0]             wr_req_row,
    input  logic [NUM_PROCS-1:0]           wr_asg_row,
    output logic [NUM_RES-1:0]             req_row,
    output logic [NUM_PROCS-1:0]           asg_row
);
    import rag_pkg::*;

    logic [NUM_RES-1:0]   req_mem [NUM_PROCS];
    logic [NUM_PROCS-1:0] asg_mem [NUM_RES];

    logic [NUM_RES-1:0]   req_data_reg;
    logic [NUM_PROCS-1:0] asg_data_reg;
    logic [NUM_PROCS-1:0] req_vld_reg;
    logic [NUM_RES-1:0]   asg_vld_reg;
    logic                 req_rvld_reg;
    logic                 asg_rvld_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_req)
        begin
            req_mem[wr_p_addr] <= wr_req_row;
        end
        if (ctl.rd_req)
        begin
            req_data_reg <= req_mem[rd_p_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_asg)
        begin
            asg_mem[wr_r_addr] <= wr_asg_row;
        end
        if (ctl.rd_asg)
        begin
            asg_data_reg <= asg_mem[rd_r_addr];
        end
    end

    // Rows never written read as empty.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_vld_reg  <= '0;
            asg_vld_reg  <= '0;
            req_rvld_reg <= 1'b0;
            asg_rvld_reg <= 1'b0;
        end
        else
        begin
            if (ctl.wr_req)
            begin
                req_vld_reg[wr_p_addr] <= 1'b1;
            end
            if (ctl.wr_asg)
            begin
                asg_vld_reg[wr_r_addr] <= 1'b1;
            end
            if (ctl.rd_req)
            begin
                req_rvld_reg <= req_vld_reg[rd_p_addr];
            end
            if (ctl.rd_asg)
            begin
                asg_rvld_reg <= asg_vld_reg[rd_r_addr];
            end
        end
    end

    assign req_row = req_rvld_reg ? req_data_reg : '0;
    assign asg_row = asg_rvld_reg ? asg_data_reg : '0;

endmodule

>>> rtl/core/rag_out_reg.sv
module rag_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  rag_pkg::result_t data,
    output logic             free,
    rag_stream_if.source     out_ch
);
    import rag_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data;
        end
    end

    assign free         = !valid_reg || out_ch.ready;
    assign out_ch.valid = valid_reg;
    assign out_ch.data  = data_reg;

endmodule

>>> rtl/core/rag_peel_engine.sv
`include "rag_deadlock_detector_macros.svh"

module rag_peel_engine #(
    parameter int NUM_PROCS = 32,
    parameter int NUM_RES   = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    rag_stream_if.sink                     in_ch,
    output rag_pkg::mem_ctl_t              mem_ctl,
    output logic [$clog2(NUM_PROCS)-1:0]   rd_p_addr,
    output logic [$clog2(NUM_RES)-1:0]     rd_r_addr,
    output logic [$clog2(NUM_PROCS)-1:0]   wr_p_addr,
    output logic [$clog2(NUM_RES)-1:0]     wr_r_addr,
    output logic [NUM_RES-1:0]             wr_req_row,
    output logic [NUM_PROCS-1:0]           wr_asg_row,
    input  logic [NUM_RES-1:0]             req_row,
    input  logic [NUM_PROCS-1:0]           asg_row,
    output logic                           out_load,
    output rag_pkg::result_t               out_data,
    input  logic                           out_free
);
    import rag_pkg::*;

    localparam int PW   = $clog2(NUM_PROCS);
    localparam int RW   = $clog2(NUM_RES);
    localparam int NMAX = (NUM_PROCS > NUM_RES) ? NUM_PROCS : NUM_RES;
    localparam int CW   = $clog2(NMAX);

    localparam logic [NUM_PROCS-1:0] P_ONE = {{(NUM_PROCS-1){1'b0}}, 1'b1};
    localparam logic [NUM_RES-1:0]   R_ONE = {{(NUM_RES-1){1'b0}}, 1'b1};
    localparam logic [CW-1:0]        LAST_IDX = CW'(NMAX - 1);

    state_t               state_reg, state_next;
    logic                 stopped_reg, stopped_next;
    logic [IDX_W-1:0]     cnt_reg, cnt_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [PW-1:0]        p_reg, p_next;
    logic [RW-1:0]        r_reg, r_next;
    logic                 asg_reg, asg_next;
    logic                 hit_reg, hit_next;
    logic [NUM_PROCS-1:0] alive_p_reg, alive_p_next;
    logic [NUM_RES-1:0]   alive_r_reg, alive_r_next;
    logic [NUM_PROCS-1:0] wap_reg, wap_next;
    logic [NUM_RES-1:0]   war_reg, war_next;
    logic [CW-1:0]        rd_idx_reg, rd_idx_next;
    logic                 rd_done_reg, rd_done_next;
    logic                 ev_vld_reg, ev_vld_next;
    logic [CW-1:0]        ev_idx_reg, ev_idx_next;
    logic                 chg_reg, chg_next;
    logic [PW-1:0]        scan_reg, scan_next;
    status_t              emit_st_reg, emit_st_next;

    logic                 accept;
    logic                 in_hit;
    logic                 drop_p;
    logic                 drop_r;
    logic                 pass_end;
    logic                 pass_chg;
    logic [NUM_PROCS-1:0] wap_eval;
    logic [NUM_RES-1:0]   war_eval;
    logic [NUM_PROCS-1:0] scan_rem;
    logic                 scan_hit;
    logic                 scan_last;
    logic                 ev_in_p;
    logic                 ev_in_r;
    logic                 rd_in_p;
    logic                 rd_in_r;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign in_hit      = ({2'b00, in_ch.data.proc_id} < 7'(NUM_PROCS))
                      && ({2'b00, in_ch.data.res_id} < 7'(NUM_RES));

    assign ev_in_p = {1'b0, ev_idx_reg} < (CW+1)'(NUM_PROCS);
    assign ev_in_r = {1'b0, ev_idx_reg} < (CW+1)'(NUM_RES);
    assign rd_in_p = {1'b0, rd_idx_reg} < (CW+1)'(NUM_PROCS);
    assign rd_in_r = {1'b0, rd_idx_reg} < (CW+1)'(NUM_RES);

    // A node drops when it has no outgoing edge to a node still present.
    assign drop_p = ev_vld_reg && ev_in_p && wap_reg[ev_idx_reg[PW-1:0]]
                 && ((req_row & war_reg) == '0);
    assign drop_r = ev_vld_reg && ev_in_r && war_reg[ev_idx_reg[RW-1:0]]
                 && ((asg_row & wap_reg) == '0);
    assign wap_eval = drop_p ? (wap_reg & ~(P_ONE << ev_idx_reg[PW-1:0])) : wap_reg;
    assign war_eval = drop_r ? (war_reg & ~(R_ONE << ev_idx_reg[RW-1:0])) : war_reg;
    assign pass_end = ev_vld_reg && (ev_idx_reg == LAST_IDX);
    assign pass_chg = chg_reg || drop_p || drop_r;

    assign scan_hit  = wap_reg[scan_reg];
    assign scan_rem  = wap_reg & ~(P_ONE << scan_reg);
    assign scan_last = (scan_rem == '0);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = stopped_reg ? S_EMIT : S_UPD;
                end
            end
            S_UPD:
            begin
                state_next = S_SWEEP;
            end
            S_SWEEP:
            begin
                if (pass_end && !pass_chg)
                begin
                    state_next = (wap_eval == '0) ? S_EMIT : S_REPORT;
                end
            end
            S_REPORT:
            begin
                if (scan_hit && out_free && scan_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        stopped_next = stopped_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        p_next       = p_reg;
        r_next       = r_reg;
        asg_next     = asg_reg;
        hit_next     = hit_reg;
        alive_p_next = alive_p_reg;
        alive_r_next = alive_r_reg;
        wap_next     = wap_reg;
        war_next     = war_reg;
        rd_idx_next  = rd_idx_reg;
        rd_done_next = rd_done_reg;
        ev_vld_next  = 1'b0;
        ev_idx_next  = ev_idx_reg;
        chg_next     = chg_reg;
        scan_next    = scan_reg;
        emit_st_next = emit_st_reg;
        mem_ctl      = '0;
        rd_p_addr    = rd_idx_reg[PW-1:0];
        rd_r_addr    = rd_idx_reg[RW-1:0];
        wr_p_addr    = p_reg;
        wr_r_addr    = r_reg;
        wr_req_row   = req_row | (R_ONE << r_reg);
        wr_asg_row   = asg_row | (P_ONE << p_reg);
        out_load     = 1'b0;
        out_data     = '{status: emit_st_reg, edge_num: idx_reg,
                         dead_proc: '0, last: 1'b1};
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    idx_next     = cnt_reg;
                    cnt_next     = (cnt_reg != IDX_MAX) ? cnt_reg + 1'b1 : cnt_reg;
                    emit_st_next = ST_HALTED;
                    p_next       = PW'({2'b00, in_ch.data.proc_id});
                    r_next       = RW'({2'b00, in_ch.data.res_id});
                    asg_next     = in_ch.data.is_assign;
                    hit_next     = in_hit;
                    rd_p_addr    = PW'({2'b00, in_ch.data.proc_id});
                    rd_r_addr    = RW'({2'b00, in_ch.data.res_id});
                    mem_ctl.rd_req = !stopped_reg && in_hit;
                    mem_ctl.rd_asg = !stopped_reg && in_hit;
                end
            end
            S_UPD:
            begin
                if (hit_reg)
                begin
                    mem_ctl.wr_req = !asg_reg;
                    mem_ctl.wr_asg = asg_reg;
                    alive_p_next   = alive_p_reg | (P_ONE << p_reg);
                    alive_r_next   = alive_r_reg | (R_ONE << r_reg);
                end
                wap_next     = alive_p_next;
                war_next     = alive_r_next;
                rd_idx_next  = '0;
                rd_done_next = 1'b0;
                chg_next     = 1'b0;
            end
            S_SWEEP:
            begin
                if (!rd_done_reg)
                begin
                    mem_ctl.rd_req = rd_in_p;
                    mem_ctl.rd_asg = rd_in_r;
                    ev_vld_next    = 1'b1;
                    ev_idx_next    = rd_idx_reg;
                    if (rd_idx_reg == LAST_IDX)
                    begin
                        rd_done_next = 1'b1;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + 1'b1;
                    end
                end
                wap_next = wap_eval;
                war_next = war_eval;
                chg_next = pass_chg;
                if (pass_end)
                begin
                    rd_idx_next  = '0;
                    rd_done_next = 1'b0;
                    chg_next     = 1'b0;
                    scan_next    = '0;
                    emit_st_next = ST_CLEAR;
                end
            end
            S_REPORT:
            begin
                if (scan_hit)
                begin
                    if (out_free)
                    begin
                        out_load = 1'b1;
                        out_data = '{status: ST_DEAD, edge_num: idx_reg,
                                     dead_proc: ID_W'(scan_reg), last: scan_last};
                        wap_next = scan_rem;
                        if (scan_last)
                        begin
                            stopped_next = 1'b1;
                        end
                        else
                        begin
                            scan_next = scan_reg + 1'b1;
                        end
                    end
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_EMIT:
            begin
                out_load = out_free;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            stopped_reg <= 1'b0;
            cnt_reg     <= '0;
            alive_p_reg <= '0;
            alive_r_reg <= '0;
            rd_done_reg <= 1'b0;
            ev_vld_reg  <= 1'b0;
            chg_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            stopped_reg <= stopped_next;
            cnt_reg     <= cnt_next;
            alive_p_reg <= alive_p_next;
            alive_r_reg <= alive_r_next;
            rd_done_reg <= rd_done_next;
            ev_vld_reg  <= ev_vld_next;
            chg_reg     <= chg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        p_reg       <= p_next;
        r_reg       <= r_next;
        asg_reg     <= asg_next;
        hit_reg     <= hit_next;
        wap_reg     <= wap_next;
        war_reg     <= war_next;
        rd_idx_reg  <= rd_idx_next;
        ev_idx_reg  <= ev_idx_next;
        scan_reg    <= scan_next;
        emit_st_reg <= emit_st_next;
    end

    `RAG_ASSERT(a_load_when_free, out_load |-> out_free, "result loaded into a full output register")
    `RAG_ASSERT(a_report_nonempty, (state_reg == S_REPORT) |-> (wap_reg != '0), "report with no deadlocked process left")
    `RAG_ASSERT(a_stop_sticky, stopped_reg |=> stopped_reg, "stopped flag cleared")
    `RAG_ASSERT(a_peel_subset, (state_reg == S_SWEEP) |-> ((wap_reg & ~alive_p_reg) == '0), "peeling set holds an absent process")

endmodule

>>> rtl/core/rag_deadlock_detector.sv
// Deadlock detector over a resource allocation graph that grows by one edge per input word.
// The in_ch channel carries an edge (proc_id, res_id, is_assign); out_ch carries result words
// (status, edge_num, dead_proc, last). Both use valid/ready; a word moves when both are high.
// Edges are kept in two row memories with registered reads. After each edge the block
// sweeps both memories, one process row and one resource row per cycle, dropping nodes with no
// edge to a node still present, and repeats the sweep until one pass drops nothing.
// Until a deadlock, an edge takes at least one sweep and at most NUM_PROCS + NUM_RES + 1
// sweeps, the most when each sweep drops a single node of a long chain.
// A deadlock then reports one word per deadlocked process in ascending id, scanning the
// process ids in turn; the last word of an edge has last set.
// After a deadlock every further edge is answered with one stopped word.
// Results wait in an output register; while the receiver stalls, the block holds only when it
// has a further result to load, so it can still take a new edge. Reset clears the graph, the
// edge counter and the stopped flag; no clearing pass is needed.
module rag_deadlock_detector #(
    parameter int NUM_PROCS = 32,
    parameter int NUM_RES   = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    rag_stream_if.sink   in_ch,
    rag_stream_if.source out_ch
);
    import rag_pkg::*;

    localparam int PW = $clog2(NUM_PROCS);
    localparam int RW = $clog2(NUM_RES);

    mem_ctl_t             mem_ctl;
    logic [PW-1:0]        rd_p_addr;
    logic [RW-1:0]        rd_r_addr;
    logic [PW-1:0]        wr_p_addr;
    logic [RW-1:0]        wr_r_addr;
    logic [NUM_RES-1:0]   wr_req_row;
    logic [NUM_PROCS-1:0] wr_asg_row;
    logic [NUM_RES-1:0]   req_row;
    logic [NUM_PROCS-1:0] asg_row;
    logic                 out_load;
    result_t              out_data;
    logic                 out_free;

    rag_graph_mem #(
        .NUM_PROCS (NUM_PROCS),
        .NUM_RES   (NUM_RES)
    ) u_mem (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (mem_ctl),
        .rd_p_addr  (rd_p_addr),
        .rd_r_addr  (rd_r_addr),
        .wr_p_addr  (wr_p_addr),
        .wr_r_addr  (wr_r_addr),
        .wr_req_row (wr_req_row),
        .wr_asg_row (wr_asg_row),
        .req_row    (req_row),
        .asg_row    (asg_row)
    );

    rag_peel_engine #(
        .NUM_PROCS (NUM_PROCS),
        .NUM_RES   (NUM_RES)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .mem_ctl    (mem_ctl),
        .rd_p_addr  (rd_p_addr),
        .rd_r_addr  (rd_r_addr),
        .wr_p_addr  (wr_p_addr),
        .wr_r_addr  (wr_r_addr),
        .wr_req_row (wr_req_row),
        .wr_asg_row (wr_asg_row),
        .req_row    (req_row),
        .asg_row    (asg_row),
        .out_load   (out_load),
        .out_data   (out_data),
        .out_free   (out_free)
    );

    rag_out_reg u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (out_load),
        .data   (out_data),
        .free   (out_free),
        .out_ch (out_ch)
    );

endmodule
